/* rtl/pts_pkg.sv */
`default_nettype none
package pts_pkg;

   localparam int MAX_THREADS = 64;
   localparam int LEVELS      = 3;
   localparam int TID_W       = 6;
   localparam int LVL_W       = 2;
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);
   localparam int SLOT_DEPTH  = LEVELS * MAX_THREADS;
   localparam int SLOT_AW     = $clog2(SLOT_DEPTH);

   localparam logic [LVL_W-1:0] LOW = LVL_W'(2);

   localparam logic [2:0] MODE_CREATE  = 3'd0;
   localparam logic [2:0] MODE_YIELD   = 3'd1;
   localparam logic [2:0] MODE_SETPRIO = 3'd2;
   localparam logic [2:0] MODE_JOIN    = 3'd3;
   localparam logic [2:0] MODE_FINISH  = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
   localparam logic [2:0] ST_NOT_RUN   = 3'd2;
   localparam logic [2:0] ST_NOT_LIVE  = 3'd3;
   localparam logic [2:0] ST_JOINED    = 3'd4;
   localparam logic [2:0] ST_EXHAUSTED = 3'd5;
   localparam logic [2:0] ST_NOTHING   = 3'd6;

   localparam logic [2:0] TS_UNUSED   = 3'd0;
   localparam logic [2:0] TS_READY    = 3'd1;
   localparam logic [2:0] TS_RUNNING  = 3'd2;
   localparam logic [2:0] TS_BLOCKED  = 3'd3;
   localparam logic [2:0] TS_FINISHED = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_PUSH_A, S_PUSH_B, S_DISP_RD, S_DISP_WR, S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [1:0]       prio;
      logic [TID_W-1:0] target_tid;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [TID_W-1:0] created_tid;
      logic [TID_W-1:0] running_tid;
      logic             idle;
   } rsp_type;

   typedef struct packed {
      logic [LVL_W-1:0] prio;
      logic [TID_W-1:0] tid;
   } wid_type;

   typedef struct packed {
      logic             rd_en;
      logic [TID_W-1:0] stat_ra;
      logic [TID_W-1:0] wid_ra;
      logic             stat_we;
      logic [TID_W-1:0] stat_wa;
      logic [2:0]       stat_wd;
      logic             wid_we;
      logic [TID_W-1:0] wid_wa;
      wid_type          wid_wd;
      logic [TID_W-1:0] wp_ra;
      logic             wp_clr;
   } tbl_ctrl_type;

   typedef struct packed {
      logic             push;
      logic             pop_rd;
      logic             pop;
      logic [LVL_W-1:0] lvl;
      logic [TID_W-1:0] tid;
   } q_ctrl_type;

endpackage
`default_nettype wire

/* rtl/pts_table.sv */
`default_nettype none
module pts_table import pts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tbl_ctrl_type tbl_ctrl,
   output logic [2:0]        stat_rd,
   output wid_type           wid_rd,
   output logic              wp_rd
);

   logic [2:0]             stat_mem [MAX_THREADS];
   wid_type                wid_mem  [MAX_THREADS];
   logic [MAX_THREADS-1:0] stat_vld_ff;
   logic [MAX_THREADS-1:0] waiter_ff;
   logic [2:0]             stat_raw_ff;
   logic                   vld_rd_ff;
   logic                   zero_rd_ff;
   wid_type                wid_rd_ff;

   // Entries never written read as unused, except thread 0 which runs at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_vld_ff <= '0;
         waiter_ff   <= '0;
      end else begin
         if (tbl_ctrl.stat_we) stat_vld_ff[tbl_ctrl.stat_wa] <= 1'b1;
         if (tbl_ctrl.wid_we)  waiter_ff[tbl_ctrl.wid_wa]    <= 1'b1;
         if (tbl_ctrl.wp_clr)  waiter_ff[tbl_ctrl.wp_ra]     <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_ctrl.stat_we) stat_mem[tbl_ctrl.stat_wa] <= tbl_ctrl.stat_wd;
      if (tbl_ctrl.rd_en) begin
         stat_raw_ff <= stat_mem[tbl_ctrl.stat_ra];
         vld_rd_ff   <= stat_vld_ff[tbl_ctrl.stat_ra];
         zero_rd_ff  <= (tbl_ctrl.stat_ra == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_ctrl.wid_we) wid_mem[tbl_ctrl.wid_wa] <= tbl_ctrl.wid_wd;
      if (tbl_ctrl.rd_en)  wid_rd_ff <= wid_mem[tbl_ctrl.wid_ra];
   end

   always_comb begin
      if (vld_rd_ff)       stat_rd = stat_raw_ff;
      else if (zero_rd_ff) stat_rd = TS_RUNNING;
      else                 stat_rd = TS_UNUSED;
   end

   assign wid_rd = wid_rd_ff;
   assign wp_rd  = waiter_ff[tbl_ctrl.wp_ra];

endmodule
`default_nettype wire

/* rtl/pts_queue.sv */
`default_nettype none
module pts_queue import pts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire q_ctrl_type  q_ctrl,
   output logic [LEVELS-1:0] nonempty,
   output logic [TID_W-1:0]  head_tid
);

   localparam logic [SLOT_AW-1:0] QSTRIDE = SLOT_AW'(MAX_THREADS);
   localparam logic [CNT_W:0]     WRAP    = (CNT_W+1)'(MAX_THREADS);

   logic [TID_W-1:0] slot_mem [SLOT_DEPTH];
   logic [TID_W-1:0] head_ff  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [TID_W-1:0] head_tid_ff;
   logic [CNT_W:0]   tail_sum;
   logic [TID_W-1:0] tail_pos;
   logic [SLOT_AW-1:0] base;
   logic [SLOT_AW-1:0] wr_addr;
   logic [SLOT_AW-1:0] rd_addr;
   logic             full;
   logic [TID_W-1:0] head_next;

   always_comb begin
      base     = SLOT_AW'(q_ctrl.lvl) * QSTRIDE;
      tail_sum = (CNT_W+1)'(head_ff[q_ctrl.lvl]) + (CNT_W+1)'(count_ff[q_ctrl.lvl]);
      if (tail_sum >= WRAP) tail_pos = TID_W'(tail_sum - WRAP);
      else                  tail_pos = TID_W'(tail_sum);
      wr_addr  = base + SLOT_AW'(tail_pos);
      rd_addr  = base + SLOT_AW'(head_ff[q_ctrl.lvl]);
      full     = (count_ff[q_ctrl.lvl] >= CNT_W'(MAX_THREADS));
      if ((CNT_W+1)'(head_ff[q_ctrl.lvl]) + 1'b1 >= WRAP) head_next = '0;
      else head_next = head_ff[q_ctrl.lvl] + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (q_ctrl.push && !full) begin
         count_ff[q_ctrl.lvl] <= count_ff[q_ctrl.lvl] + 1'b1;
      end else if (q_ctrl.pop) begin
         head_ff[q_ctrl.lvl]  <= head_next;
         count_ff[q_ctrl.lvl] <= count_ff[q_ctrl.lvl] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctrl.push && !full) slot_mem[wr_addr] <= q_ctrl.tid;
      if (q_ctrl.pop_rd)        head_tid_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      for (int i = 0; i < LEVELS; i++) nonempty[i] = (count_ff[i] != '0);
   end

   assign head_tid = head_tid_ff;

endmodule
`default_nettype wire

/* rtl/priority_thread_scheduler.sv */
`default_nettype none
// Priority thread scheduler: three FIFO ready queues (level 0 highest) and
// one running thread. Each request word carries one event (create, yield,
// set priority, join, finish); each event returns exactly one response word
// with a status, the id given by a create, the running id and an idle flag.
// Both channels use valid/stall: a word moves on a rising edge where valid
// is high and stall is low.
// The path from request to response valid runs through the thread table
// read, up to two queue appends (one slot-memory write each) and the head
// read and pop of the dispatch. A new request is taken once the previous
// event has reached the response register.
// The response register holds a finished word while rsp_stall is high; the
// next request may be accepted meanwhile and waits in the response state.
// Reset (synchronous): thread 0 runs at the lowest level, all queues empty,
// no waiters, no ids given out. No clearing pass is needed.
module priority_thread_scheduler import pts_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_word
);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [TID_W-1:0] run_id_ff, run_id_in;
   logic             run_present_ff, run_present_in;
   logic [LVL_W-1:0] run_prio_ff, run_prio_in;
   logic [TID_W-1:0] last_id_ff, last_id_in;
   logic             used_up_ff, used_up_in;
   logic [2:0]       status_ff, status_in;
   logic [TID_W-1:0] created_ff, created_in;
   logic             push_a_ff, push_a_in;
   wid_type          a_ff, a_in;
   logic             push_b_ff, push_b_in;
   wid_type          b_ff, b_in;
   logic [LVL_W-1:0] sel_lvl_ff, sel_lvl_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   tbl_ctrl_type     tbl_ctrl;
   logic [2:0]       stat_rd;
   wid_type          wid_rd;
   logic             wp_rd;
   q_ctrl_type       q_ctrl;
   logic [LEVELS-1:0] nonempty;
   logic [TID_W-1:0] head_tid;
   logic [TID_W-1:0] new_id;

   pts_table u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl_ctrl (tbl_ctrl),
      .stat_rd  (stat_rd),
      .wid_rd   (wid_rd),
      .wp_rd    (wp_rd)
   );

   pts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_ctrl   (q_ctrl),
      .nonempty (nonempty),
      .head_tid (head_tid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         run_id_ff      <= '0;
         run_present_ff <= 1'b1;
         run_prio_ff    <= LOW;
         last_id_ff     <= '0;
         used_up_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         push_a_ff      <= 1'b0;
         push_b_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         run_id_ff      <= run_id_in;
         run_present_ff <= run_present_in;
         run_prio_ff    <= run_prio_in;
         last_id_ff     <= last_id_in;
         used_up_ff     <= used_up_in;
         rsp_valid_ff   <= rsp_valid_in;
         push_a_ff      <= push_a_in;
         push_b_ff      <= push_b_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      created_ff <= created_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      sel_lvl_ff <= sel_lvl_in;
      rsp_ff     <= rsp_in;
   end

   assign new_id = last_id_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      run_id_in      = run_id_ff;
      run_present_in = run_present_ff;
      run_prio_in    = run_prio_ff;
      last_id_in     = last_id_ff;
      used_up_in     = used_up_ff;
      status_in      = status_ff;
      created_in     = created_ff;
      push_a_in      = push_a_ff;
      a_in           = a_ff;
      push_b_in      = push_b_ff;
      b_in           = b_ff;
      sel_lvl_in     = sel_lvl_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      req_stall      = 1'b1;
      tbl_ctrl       = '0;
      tbl_ctrl.wid_ra = run_id_ff;
      tbl_ctrl.wp_ra  = run_id_ff;
      q_ctrl         = '0;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in           = req_word;
               tbl_ctrl.rd_en   = 1'b1;
               tbl_ctrl.stat_ra = req_word.target_tid;
               state_in         = S_EVAL;
            end
         end

         S_EVAL: begin
            status_in  = ST_OK;
            created_in = '0;
            push_a_in  = 1'b0;
            push_b_in  = 1'b0;
            if (req_ff.mode == MODE_JOIN) tbl_ctrl.wp_ra = req_ff.target_tid;
            if (req_ff.mode == MODE_CREATE) begin
               if (req_ff.prio == LVL_W'(LEVELS)) begin
                  status_in = ST_BAD_PRIO;
               end else if (used_up_ff) begin
                  status_in = ST_EXHAUSTED;
               end else begin
                  last_id_in = new_id;
                  if (new_id == TID_W'(MAX_THREADS - 1)) used_up_in = 1'b1;
                  created_in = new_id;
                  push_a_in  = 1'b1;
                  a_in.tid   = new_id;
                  a_in.prio  = req_ff.prio;
                  // Preempt a running thread of lower urgency.
                  if (run_present_ff && run_prio_ff > req_ff.prio) begin
                     push_b_in      = 1'b1;
                     b_in.tid       = run_id_ff;
                     b_in.prio      = run_prio_ff;
                     run_present_in = 1'b0;
                  end
               end
            end else if (req_ff.mode <= MODE_FINISH && !run_present_ff) begin
               status_in = ST_NOTHING;
            end else if (req_ff.mode == MODE_YIELD) begin
               push_b_in      = 1'b1;
               b_in.tid       = run_id_ff;
               b_in.prio      = run_prio_ff;
               run_present_in = 1'b0;
            end else if (req_ff.mode == MODE_SETPRIO) begin
               if (req_ff.target_tid != run_id_ff) begin
                  status_in = ST_NOT_RUN;
               end else if (req_ff.prio == LVL_W'(LEVELS)) begin
                  status_in = ST_BAD_PRIO;
               end else begin
                  run_prio_in    = req_ff.prio;
                  push_b_in      = 1'b1;
                  b_in.tid       = run_id_ff;
                  b_in.prio      = req_ff.prio;
                  run_present_in = 1'b0;
               end
            end else if (req_ff.mode == MODE_JOIN) begin
               if (stat_rd != TS_READY && stat_rd != TS_BLOCKED) begin
                  status_in = ST_NOT_LIVE;
               end else if (wp_rd) begin
                  status_in = ST_JOINED;
               end else begin
                  tbl_ctrl.wid_we      = 1'b1;
                  tbl_ctrl.wid_wa      = req_ff.target_tid;
                  tbl_ctrl.wid_wd.tid  = run_id_ff;
                  tbl_ctrl.wid_wd.prio = run_prio_ff;
                  tbl_ctrl.stat_we     = 1'b1;
                  tbl_ctrl.stat_wa     = run_id_ff;
                  tbl_ctrl.stat_wd     = TS_BLOCKED;
                  run_present_in       = 1'b0;
               end
            end else if (req_ff.mode == MODE_FINISH) begin
               run_present_in   = 1'b0;
               tbl_ctrl.stat_we = 1'b1;
               tbl_ctrl.stat_wa = run_id_ff;
               tbl_ctrl.stat_wd = TS_FINISHED;
               // Release the waiter, if any.
               if (wp_rd) begin
                  tbl_ctrl.wp_clr = 1'b1;
                  push_a_in       = 1'b1;
                  a_in            = wid_rd;
               end
            end
            if (push_a_in)      state_in = S_PUSH_A;
            else if (push_b_in) state_in = S_PUSH_B;
            else                state_in = S_DISP_RD;
         end

         S_PUSH_A: begin
            q_ctrl.push      = 1'b1;
            q_ctrl.lvl       = a_ff.prio;
            q_ctrl.tid       = a_ff.tid;
            tbl_ctrl.stat_we = 1'b1;
            tbl_ctrl.stat_wa = a_ff.tid;
            tbl_ctrl.stat_wd = TS_READY;
            state_in         = push_b_ff ? S_PUSH_B : S_DISP_RD;
         end

         S_PUSH_B: begin
            q_ctrl.push      = 1'b1;
            q_ctrl.lvl       = b_ff.prio;
            q_ctrl.tid       = b_ff.tid;
            tbl_ctrl.stat_we = 1'b1;
            tbl_ctrl.stat_wa = b_ff.tid;
            tbl_ctrl.stat_wd = TS_READY;
            state_in         = S_DISP_RD;
         end

         S_DISP_RD: begin
            // When no thread runs, pick the highest non-empty level and read its head slot.
            if (!run_present_ff && nonempty != '0) begin
               if (nonempty[0])      sel_lvl_in = LVL_W'(0);
               else if (nonempty[1]) sel_lvl_in = LVL_W'(1);
               else                  sel_lvl_in = LVL_W'(2);
               q_ctrl.pop_rd = 1'b1;
               q_ctrl.lvl    = sel_lvl_in;
               state_in      = S_DISP_WR;
            end else begin
               state_in = S_RESP;
            end
         end

         S_DISP_WR: begin
            q_ctrl.pop       = 1'b1;
            q_ctrl.lvl       = sel_lvl_ff;
            run_id_in        = head_tid;
            run_present_in   = 1'b1;
            run_prio_in      = sel_lvl_ff;
            tbl_ctrl.stat_we = 1'b1;
            tbl_ctrl.stat_wa = head_tid;
            tbl_ctrl.stat_wd = TS_RUNNING;
            state_in         = S_RESP;
         end

         S_RESP: begin
            // Hold here while the previous word still sits stalled.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status      = status_ff;
               rsp_in.created_tid = created_ff;
               rsp_in.running_tid = run_present_ff ? run_id_ff : '0;
               rsp_in.idle        = !run_present_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EVAL))
      else $error("accepted request did not advance to evaluation");

   a_dispatch_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP_WR) |=> run_present_ff)
      else $error("dispatch left no running thread");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      run_present_ff |-> (run_prio_ff != LVL_W'(LEVELS)))
      else $error("running thread holds an invalid level");

   a_ids_used: assert property (@(posedge clock) disable iff (reset)
      used_up_ff |-> (last_id_ff == TID_W'(MAX_THREADS - 1)))
      else $error("id pool marked exhausted early");

endmodule
`default_nettype wire
